// ===== src/spfa_pkg.sv =====
package spfa_pkg;

	// Default sizes of the stores.
	localparam int NODES_DEF = 1024;
	localparam int EDGES_DEF = 8192;
	localparam int DIST_BITS_DEF = 32;

	// Fixed field widths of the command and result words.
	localparam int CMD_BITS = 2;
	localparam int NODE_BITS = 10;
	localparam int WEIGHT_BITS = 16;
	localparam int LEN_BITS = 32;

	// Status codes of a result word.
	localparam logic ST_OK = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD = 2'd1,
		CMD_SOLVE = 2'd2,
		CMD_READ = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_ADD_RA,
		S_ADD_WA,
		S_ADD_RB,
		S_ADD_WB,
		S_READ,
		S_RDATA,
		S_SEED,
		S_POP,
		S_U,
		S_HEAD,
		S_EDGE,
		S_EW,
		S_REL,
		S_DONE
	} state_t;

endpackage

// ===== src/spfa_cmd_if.sv =====
interface spfa_cmd_if
	import spfa_pkg::*;
();
	logic valid;
	logic ready;
	logic [CMD_BITS-1:0] command;
	logic [NODE_BITS-1:0] node_a;
	logic [NODE_BITS-1:0] node_b;
	logic [WEIGHT_BITS-1:0] edge_weight;

	modport source(output valid, command, node_a, node_b, edge_weight, input ready);
	modport sink(input valid, command, node_a, node_b, edge_weight, output ready);
endinterface

// ===== src/spfa_res_if.sv =====
interface spfa_res_if
	import spfa_pkg::*;
();
	logic valid;
	logic ready;
	logic status;
	logic [LEN_BITS-1:0] path_length;
	logic reachable;

	modport source(output valid, status, path_length, reachable, input ready);
	modport sink(input valid, status, path_length, reachable, output ready);
endinterface

// ===== src/spfa_ram.sv =====
module spfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== src/spfa_relax.sv =====
module spfa_relax #(
	parameter int DIST_BITS = 32
) (
	input  logic                 clk,
	input  logic                 load,
	input  logic [DIST_BITS-1:0] dist_u,
	input  logic [15:0]          cost,
	input  logic [DIST_BITS-1:0] dist_v,
	output logic [DIST_BITS-1:0] cand,
	output logic                 better
);
	logic [DIST_BITS:0]   sum;
	logic [DIST_BITS-1:0] cand_q;

	// Saturating add; a carry out means the sum reached infinity or beyond.
	assign sum = {1'b0, dist_u} + (DIST_BITS + 1)'(cost);

	always_ff @(posedge clk) begin
		if (load) begin
			cand_q <= sum[DIST_BITS] ? '1 : sum[DIST_BITS-1:0];
		end
	end

	// The candidate wins only when strictly shorter.
	assign cand = cand_q;
	assign better = cand_q < dist_v;
endmodule

// ===== src/spfa_shortest_path_engine.sv =====
// Channel | Dir | Word
// cmd     | in  | command, node_a, node_b, edge_weight
// res     | out | status, path_length, reachable (one word per command)
//
// Clear sweeps the head store, add reads and writes the head store for each end in turn,
// and read fetches one distance word. Solve first resets every distance, then for each
// dequeued node walks its adjacency entries through the shared relax unit.
// After reset a clearing pass over every node runs before the first command is taken.
// One command is worked at a time; cmd.ready is low until its result word is taken.
module spfa_shortest_path_engine
	import spfa_pkg::*;
#(
	parameter int MAX_NODES = NODES_DEF,
	parameter int MAX_EDGES = EDGES_DEF,
	parameter int DIST_BITS = DIST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	spfa_cmd_if.sink    cmd,
	spfa_res_if.source  res
);
	localparam int AW = $clog2(MAX_NODES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int PW = $clog2(MAX_EDGES + 1);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int EDW = NODE_BITS + WEIGHT_BITS + PW;
	localparam logic [DIST_BITS-1:0] DINF = '1;

	state_t state_q, state_d;

	// Latched command.
	logic [NODE_BITS-1:0]   a_q, b_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic                   a_ok_q;

	// Sequencer registers.
	logic [AW-1:0]        sw_cnt_q;
	logic                 sw_head_q, sw_dist_q;
	logic [PW-1:0]        ecount_q;
	logic [AW-1:0]        rd_q, wr_q;
	logic [CW-1:0]        fcnt_q;
	logic [AW-1:0]        u_q, v_q;
	logic [DIST_BITS-1:0] du_q;
	logic [PW-1:0]        p_q;

	// Result registers.
	logic                 out_valid_q, status_q, reach_q;
	logic [LEN_BITS-1:0]  len_q;

	// Memory ports.
	logic                 head_we, edge_we, dist_we, pend_we, fifo_we;
	logic [AW-1:0]        head_wa, head_ra, dist_wa, dist_ra, pend_wa, pend_ra;
	logic [AW-1:0]        fifo_wa, fifo_ra;
	logic [PW-1:0]        head_wd, head_rd;
	logic [EW-1:0]        edge_wa, edge_ra;
	logic [EDW-1:0]       edge_wd, edge_rd;
	logic [DIST_BITS-1:0] dist_wd, dist_rd;
	logic                 pend_wd, pend_rd;
	logic [AW-1:0]        fifo_wd, fifo_rd;

	logic                 relax_load, better;
	logic [DIST_BITS-1:0] cand;

	logic                 accept, a_in_ok, b_in_ok, sw_last, full, p_ok, v_ok;
	logic [NODE_BITS-1:0] e_target;
	logic [WEIGHT_BITS-1:0] e_cost;
	logic [PW-1:0]        e_link;

	assign accept = cmd.valid & cmd.ready;
	assign cmd.ready = (state_q == S_IDLE) && !out_valid_q;
	assign a_in_ok = 32'(cmd.node_a) < 32'(MAX_NODES);
	assign b_in_ok = 32'(cmd.node_b) < 32'(MAX_NODES);
	assign sw_last = sw_cnt_q == AW'(MAX_NODES - 1);
	assign full = ecount_q > PW'(MAX_EDGES - 2);
	assign p_ok = (p_q != '0) && (p_q <= PW'(MAX_EDGES));
	assign {e_target, e_cost, e_link} = edge_rd;
	assign v_ok = 32'(e_target) < 32'(MAX_NODES);

	assign res.valid = out_valid_q;
	assign res.status = status_q;
	assign res.path_length = len_q;
	assign res.reachable = reach_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (sw_last) begin
					if (sw_head_q && sw_dist_q) state_d = S_IDLE;
					else if (sw_head_q) state_d = S_DONE;
					else if (a_ok_q) state_d = S_SEED;
					else state_d = S_DONE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(cmd.command))
						CMD_CLEAR: state_d = S_SWEEP;
						CMD_ADD: state_d = (!full && a_in_ok && b_in_ok) ? S_ADD_RA : S_DONE;
						CMD_SOLVE: state_d = S_SWEEP;
						CMD_READ: state_d = a_in_ok ? S_READ : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ADD_RA: state_d = S_ADD_WA;
			S_ADD_WA: state_d = S_ADD_RB;
			S_ADD_RB: state_d = S_ADD_WB;
			S_ADD_WB: state_d = S_DONE;
			S_READ:   state_d = S_RDATA;
			S_RDATA:  state_d = S_DONE;
			S_SEED:   state_d = S_POP;
			S_POP:    state_d = (fcnt_q == '0) ? S_DONE : S_U;
			S_U:      state_d = S_HEAD;
			S_HEAD:   state_d = S_EDGE;
			S_EDGE:   state_d = p_ok ? S_EW : S_POP;
			S_EW:     state_d = v_ok ? S_REL : S_EDGE;
			S_REL:    state_d = S_EDGE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		head_we = 1'b0; head_wa = sw_cnt_q; head_wd = '0; head_ra = AW'(a_q);
		edge_we = 1'b0; edge_wa = ecount_q[EW-1:0]; edge_wd = '0; edge_ra = '0;
		dist_we = 1'b0; dist_wa = sw_cnt_q; dist_wd = DINF; dist_ra = AW'(a_q);
		pend_we = 1'b0; pend_wa = sw_cnt_q; pend_wd = 1'b0; pend_ra = v_q;
		fifo_we = 1'b0; fifo_wa = wr_q; fifo_wd = v_q; fifo_ra = rd_q;
		relax_load = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				head_we = sw_head_q;
				dist_we = sw_dist_q;
				pend_we = sw_dist_q;
			end
			S_ADD_RA: head_ra = AW'(a_q);
			S_ADD_WA: begin
				edge_we = 1'b1;
				edge_wd = {b_q, w_q, head_rd};
				head_we = 1'b1;
				head_wa = AW'(a_q);
				head_wd = ecount_q + PW'(1);
			end
			S_ADD_RB: head_ra = AW'(b_q);
			S_ADD_WB: begin
				edge_we = 1'b1;
				edge_wd = {a_q, w_q, head_rd};
				head_we = 1'b1;
				head_wa = AW'(b_q);
				head_wd = ecount_q + PW'(1);
			end
			S_READ: dist_ra = AW'(a_q);
			S_SEED: begin
				dist_we = 1'b1;
				dist_wa = AW'(a_q);
				dist_wd = '0;
				pend_we = 1'b1;
				pend_wa = AW'(a_q);
				pend_wd = 1'b1;
				fifo_we = 1'b1;
				fifo_wa = '0;
				fifo_wd = AW'(a_q);
			end
			S_POP: fifo_ra = rd_q;
			S_U: begin
				dist_ra = fifo_rd;
				head_ra = fifo_rd;
				pend_we = 1'b1;
				pend_wa = fifo_rd;
				pend_wd = 1'b0;
			end
			S_EDGE: edge_ra = EW'(p_q - PW'(1));
			S_EW: begin
				dist_ra = AW'(e_target);
				pend_ra = AW'(e_target);
				relax_load = 1'b1;
			end
			S_REL: begin
				dist_we = better;
				dist_wa = v_q;
				dist_wd = cand;
				pend_we = better && !pend_rd;
				pend_wa = v_q;
				pend_wd = 1'b1;
				fifo_we = better && !pend_rd;
			end
			default: ;
		endcase
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sw_cnt_q <= '0;
			sw_head_q <= 1'b1;
			sw_dist_q <= 1'b1;
			ecount_q <= '0;
			rd_q <= '0;
			wr_q <= '0;
			fcnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res.valid && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					sw_cnt_q <= sw_last ? '0 : sw_cnt_q + AW'(1);
				end
				S_IDLE: begin
					if (accept) begin
						unique case (cmd_t'(cmd.command))
							CMD_CLEAR: begin
								sw_head_q <= 1'b1;
								sw_dist_q <= 1'b0;
								ecount_q <= '0;
							end
							CMD_SOLVE: begin
								sw_head_q <= 1'b0;
								sw_dist_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_ADD_WA, S_ADD_WB: ecount_q <= ecount_q + PW'(1);
				S_SEED: begin
					rd_q <= '0;
					wr_q <= AW'(1);
					fcnt_q <= CW'(1);
				end
				S_POP: begin
					if (fcnt_q != '0) begin
						rd_q <= (rd_q == AW'(MAX_NODES - 1)) ? '0 : rd_q + AW'(1);
						fcnt_q <= fcnt_q - CW'(1);
					end
				end
				S_REL: begin
					if (better && !pend_rd) begin
						wr_q <= (wr_q == AW'(MAX_NODES - 1)) ? '0 : wr_q + AW'(1);
						fcnt_q <= fcnt_q + CW'(1);
					end
				end
				S_DONE: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= cmd.node_a;
			b_q <= cmd.node_b;
			w_q <= cmd.edge_weight;
			a_ok_q <= a_in_ok;
			status_q <= (cmd_t'(cmd.command) == CMD_ADD && full) ? ST_FULL : ST_OK;
			len_q <= (cmd_t'(cmd.command) == CMD_READ) ? LEN_BITS'(DINF) : '0;
			reach_q <= 1'b0;
		end
		if (state_q == S_RDATA) begin
			len_q <= LEN_BITS'(dist_rd);
			reach_q <= dist_rd != DINF;
		end
		if (state_q == S_U) begin
			u_q <= fifo_rd;
		end
		if (state_q == S_HEAD) begin
			du_q <= dist_rd;
			p_q <= head_rd;
		end
		if (state_q == S_EW) begin
			p_q <= e_link;
			v_q <= AW'(e_target);
		end
	end

	spfa_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(head_ra), .rdata(head_rd)
	);

	spfa_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
		.raddr(edge_ra), .rdata(edge_rd)
	);

	spfa_ram #(.WIDTH(DIST_BITS), .DEPTH(MAX_NODES)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
		.raddr(dist_ra), .rdata(dist_rd)
	);

	spfa_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_pend (
		.clk(clk), .we(pend_we), .waddr(pend_wa), .wdata(pend_wd),
		.raddr(pend_ra), .rdata(pend_rd)
	);

	spfa_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_wa), .wdata(fifo_wd),
		.raddr(fifo_ra), .rdata(fifo_rd)
	);

	spfa_relax #(.DIST_BITS(DIST_BITS)) u_relax (
		.clk(clk), .load(relax_load), .dist_u(du_q), .cost(e_cost),
		.dist_v(dist_rd), .cand(cand), .better(better)
	);

`ifndef SYNTHESIS
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= CW'(MAX_NODES))
		else $error("work queue count beyond node count");
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ecount_q) <= 32'(MAX_EDGES))
		else $error("edge count beyond edge store");
	a_full_unreached: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.reachable |-> res.status == ST_OK)
		else $error("read result flagged as full");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("command accepted but sequencer stayed idle");
	a_self_relax: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REL && v_q == u_q |-> !better)
		else $error("self loop shortened a path");
`endif
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import spfa_pkg::*;

	localparam int NODES = NODES_DEF;
	localparam int EDGES = EDGES_DEF;
	localparam logic [LEN_BITS-1:0] DIST_INF = '1;

	// One row of the directed table; typed rows carry their expected word.
	typedef struct {
		cmd_t c;
		logic [NODE_BITS-1:0] a;
		logic [NODE_BITS-1:0] b;
		logic [WEIGHT_BITS-1:0] w;
		bit typed;
		logic st;
		logic [LEN_BITS-1:0] len;
		logic rch;
	} row_t;

	typedef struct {
		logic st;
		logic [LEN_BITS-1:0] len;
		logic rch;
	} result_t;

	logic clk;
	logic arst_n;

	spfa_cmd_if cmd_ch ();
	spfa_res_if res_ch ();

	spfa_shortest_path_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// Shadow copy of the graph and distance stores.
	int unsigned head_of[NODES];
	int unsigned tgt_of[EDGES];
	int unsigned cost_of[EDGES];
	int unsigned link_of[EDGES];
	int unsigned entries_used;
	logic [LEN_BITS-1:0] dist_of[NODES];
	bit queued[NODES];
	int unsigned walk_fifo[NODES];

	result_t pending_words[$];
	int unsigned errors;
	int unsigned words_checked;
	int unsigned adds_refused;
	int unsigned solves_done;

	int unsigned send_pct;
	int unsigned stall_pct;
	bit hold_req;
	bit hold_done;
	int unsigned hold_left;

	// Typed expectation travels with the word on the command channel.
	bit drv_typed;
	result_t drv_word;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d words still expected", pending_words.size());
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report(input string what);
		errors++;
		$display("%0t: mismatch: %s", $realtime, what);
	endtask

	function automatic void store_entry(int unsigned from, int unsigned to, int unsigned w);
		tgt_of[entries_used] = to;
		cost_of[entries_used] = w;
		link_of[entries_used] = head_of[from];
		head_of[from] = entries_used + 1;
		entries_used++;
	endfunction

	// Queue-based relaxation from one source, saturating at infinity.
	function automatic void run_solve(int unsigned src);
		int unsigned rd;
		int unsigned cnt;
		int unsigned u;
		int unsigned p;
		int unsigned v;
		int unsigned wr;
		logic [LEN_BITS:0] sum;
		logic [LEN_BITS-1:0] cand;
		for (int i = 0; i < NODES; i++) begin
			dist_of[i] = DIST_INF;
			queued[i] = 1'b0;
		end
		dist_of[src] = '0;
		walk_fifo[0] = src;
		queued[src] = 1'b1;
		rd = 0;
		cnt = 1;
		while (cnt > 0) begin
			u = walk_fifo[rd];
			rd = (rd + 1 == NODES) ? 0 : rd + 1;
			cnt--;
			queued[u] = 1'b0;
			p = head_of[u];
			while (p != 0) begin
				v = tgt_of[p-1];
				sum = {1'b0, dist_of[u]} + cost_of[p-1];
				cand = sum[LEN_BITS] ? DIST_INF : sum[LEN_BITS-1:0];
				if (cand < dist_of[v]) begin
					dist_of[v] = cand;
					if (!queued[v] && cnt < NODES) begin
						wr = rd + cnt;
						if (wr >= NODES)
							wr -= NODES;
						walk_fifo[wr] = v;
						queued[v] = 1'b1;
						cnt++;
					end
				end
				p = link_of[p-1];
			end
		end
	endfunction

	function automatic result_t predict_word(cmd_t c, int unsigned a, int unsigned b,
			int unsigned w);
		result_t r;
		r.st = ST_OK;
		r.len = '0;
		r.rch = 1'b0;
		case (c)
			CMD_CLEAR: begin
				for (int i = 0; i < NODES; i++)
					head_of[i] = 0;
				entries_used = 0;
			end
			CMD_ADD: begin
				if (entries_used > EDGES - 2) begin
					r.st = ST_FULL;
				end else begin
					store_entry(a, b, w);
					store_entry(b, a, w);
				end
			end
			CMD_SOLVE: begin
				run_solve(a);
			end
			default: begin
				r.len = dist_of[a];
				r.rch = (dist_of[a] != DIST_INF);
			end
		endcase
		return r;
	endfunction

	// Predict each accepted command word.
	always @(posedge clk) begin
		result_t r;
		if (cmd_ch.valid && cmd_ch.ready) begin
			r = predict_word(cmd_t'(cmd_ch.command), cmd_ch.node_a, cmd_ch.node_b,
				cmd_ch.edge_weight);
			if (r.st == ST_FULL)
				adds_refused++;
			if (cmd_t'(cmd_ch.command) == CMD_SOLVE)
				solves_done++;
			if (drv_typed && (r.st !== drv_word.st || r.len !== drv_word.len ||
					r.rch !== drv_word.rch))
				report($sformatf("table row disagrees with prediction for command %0d",
					cmd_ch.command));
			pending_words.push_back(drv_typed ? drv_word : r);
		end
	end

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (res_ch.valid && res_ch.ready) begin
			if (pending_words.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				e = pending_words.pop_front();
				words_checked++;
				if (res_ch.status !== e.st)
					report($sformatf("status %b, expected %b", res_ch.status, e.st));
				if (res_ch.path_length !== e.len)
					report($sformatf("path_length %h, expected %h", res_ch.path_length, e.len));
				if (res_ch.reachable !== e.rch)
					report($sformatf("reachable %b, expected %b", res_ch.reachable, e.rch));
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = 400;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(input cmd_t c, input int unsigned a, input int unsigned b,
			input int unsigned w, input bit typed = 1'b0, input result_t tw = '{0, 0, 0});
		if (send_pct > 0 && $urandom_range(99) < send_pct) begin
			cmd_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_pct);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.node_a <= a[NODE_BITS-1:0];
		cmd_ch.node_b <= b[NODE_BITS-1:0];
		cmd_ch.edge_weight <= w[WEIGHT_BITS-1:0];
		drv_typed <= typed;
		drv_word <= tw;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	function automatic int unsigned pick_weight();
		case ($urandom_range(7))
			0: return 0;
			1: return 16'hffff;
			2: return $urandom_range(16'hffff);
			default: return $urandom_range(200);
		endcase
	endfunction

	// Mostly adds and reads over a small node window, with sparse solves and clears.
	task automatic random_word(input int unsigned base);
		int unsigned pick;
		int unsigned a;
		int unsigned b;
		pick = $urandom_range(99);
		a = ($urandom_range(19) == 0) ? $urandom_range(NODES - 1) : base + $urandom_range(39);
		b = ($urandom_range(19) == 0) ? $urandom_range(NODES - 1) : base + $urandom_range(39);
		if (pick < 47)
			send_word(CMD_ADD, a, b, pick_weight());
		else if (pick < 54)
			send_word(CMD_SOLVE, a, b, $urandom_range(16'hffff));
		else if (pick < 57)
			send_word(CMD_CLEAR, a, b, $urandom_range(16'hffff));
		else
			send_word(CMD_READ, a, b, $urandom_range(16'hffff));
	endtask

	row_t dir_rows[] = '{
		'{CMD_READ,  0,    0,   0,     1, ST_OK, DIST_INF, 0},
		'{CMD_READ,  1023, 0,   0,     1, ST_OK, DIST_INF, 0},
		'{CMD_CLEAR, 0,    0,   0,     1, ST_OK, 0, 0},
		'{CMD_ADD,   0,    1023, 65535, 1, ST_OK, 0, 0},
		'{CMD_ADD,   1,    2,   0,     1, ST_OK, 0, 0},
		'{CMD_ADD,   2,    2,   7,     0, ST_OK, 0, 0},
		'{CMD_ADD,   1023, 5,   100,   0, ST_OK, 0, 0},
		'{CMD_ADD,   0,    1,   3,     0, ST_OK, 0, 0},
		'{CMD_SOLVE, 0,    0,   0,     1, ST_OK, 0, 0},
		'{CMD_READ,  0,    0,   0,     1, ST_OK, 0, 1},
		'{CMD_READ,  1023, 0,   0,     1, ST_OK, 65535, 1},
		'{CMD_READ,  2,    0,   0,     1, ST_OK, 3, 1},
		'{CMD_READ,  5,    0,   0,     0, ST_OK, 0, 0},
		'{CMD_READ,  700,  0,   0,     1, ST_OK, DIST_INF, 0},
		'{CMD_SOLVE, 1023, 0,   0,     0, ST_OK, 0, 0},
		'{CMD_READ,  0,    0,   0,     1, ST_OK, 65535, 1},
		'{CMD_ADD,   682,  341, 21845, 0, ST_OK, 0, 0},
		'{CMD_CLEAR, 1023, 1023, 65535, 0, ST_OK, 0, 0},
		'{CMD_READ,  5,    0,   0,     1, ST_OK, 100, 1},
		'{CMD_SOLVE, 5,    0,   0,     0, ST_OK, 0, 0},
		'{CMD_READ,  5,    0,   0,     1, ST_OK, 0, 1},
		'{CMD_READ,  0,    0,   0,     1, ST_OK, DIST_INF, 0}
	};

	initial begin
		int unsigned pct_send[4] = '{0, 80, 0, 10};
		int unsigned pct_stall[4] = '{0, 0, 80, 10};
		int unsigned waited;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_CLEAR;
		cmd_ch.node_a = '0;
		cmd_ch.node_b = '0;
		cmd_ch.edge_weight = '0;
		res_ch.ready = 1'b0;
		drv_typed = 1'b0;
		drv_word = '{0, 0, 0};
		send_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		errors = 0;
		words_checked = 0;
		adds_refused = 0;
		solves_done = 0;
		entries_used = 0;
		for (int i = 0; i < NODES; i++) begin
			head_of[i] = 0;
			dist_of[i] = DIST_INF;
			queued[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (dir_rows[i])
			send_word(dir_rows[i].c, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w,
				dir_rows[i].typed, '{dir_rows[i].st, dir_rows[i].len, dir_rows[i].rch});

		// Fill the edge store over a few nodes until adds are refused.
		send_word(CMD_CLEAR, 0, 0, 0);
		for (int i = 0; i < EDGES / 2 + 2; i++)
			send_word(CMD_ADD, 900 + $urandom_range(3), 900 + $urandom_range(3), pick_weight());
		send_word(CMD_SOLVE, 900, 0, 0);
		for (int n = 899; n <= 904; n++)
			send_word(CMD_READ, n, 0, 0);
		send_word(CMD_CLEAR, 0, 0, 0);

		// Random traffic under each idling mix.
		for (int m = 0; m < 4; m++) begin
			send_pct = pct_send[m];
			stall_pct = pct_stall[m];
			for (int i = 0; i < 340; i++)
				random_word((i % 170 == 0) ? 0 : $urandom_range(NODES - 40) & ~0);
		end

		// Long receiver hold-off while words keep coming, then a full drain.
		send_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 40; i++)
			random_word(100);
		cmd_ch.valid <= 1'b0;
		wait (pending_words.size() == 0);
		for (int i = 0; i < 100; i++)
			random_word(100);

		@(posedge clk);
		cmd_ch.valid <= 1'b0;
		waited = 0;
		while (pending_words.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (pending_words.size() != 0)
			report($sformatf("%0d result words never arrived", pending_words.size()));

		$display("Checked %0d result words: %0d solves, %0d adds refused on a full store,",
			words_checked, solves_done, adds_refused);
		$display("across four idling mixes and one long receiver hold-off.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
